@@ hdl/flacp_pkg.sv @@
// ----------------------------------------------------------------------------
// flacp_pkg
// Shared codes and constants for the FLAC stream header parser.
// ----------------------------------------------------------------------------
package flacp_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_STREAMINFO = 3'd0,
    KIND_FRAME      = 3'd1,
    KIND_BAD_MARKER = 3'd2,
    KIND_NOT_SINFO  = 3'd3,
    KIND_ZERO_RATE  = 3'd4,
    KIND_BAD_SYNC   = 3'd5
  } kind_e;

  localparam logic [31:0] STREAM_MARKER = 32'h664C_6143; // "fLaC"
  localparam logic [13:0] FRAME_SYNC    = 14'h3FFE;

  localparam logic [16:0] BS_CODE1      = 17'd192;
  localparam logic [16:0] BS_BASE_576   = 17'd576;
  localparam logic [16:0] BS_BASE_256   = 17'd256;

  localparam logic [3:0]  RATE_CODE_8BIT = 4'd12;
  localparam logic [3:0]  RATE_CODE_16   = 4'd13;
  localparam logic [3:0]  RATE_CODE_16X  = 4'd14;
  localparam logic [3:0]  RATE_CODE_NONE = 4'd15;
  localparam logic [3:0]  BS_CODE_8BIT   = 4'd6;
  localparam logic [3:0]  BS_CODE_16BIT  = 4'd7;

  // Index of the last streaminfo body byte and of the first rate byte
  localparam logic [23:0] SI_FIRST_ACC  = 24'd10;
  localparam logic [23:0] SI_LAST_ACC   = 24'd17;
  localparam logic [23:0] SI_LAST_BYTE  = 24'd33;
  localparam logic [23:0] SI_FF_BYTES   = 24'd4;

  // Warning bits
  localparam int unsigned WARN_RES1    = 0;
  localparam int unsigned WARN_RES2    = 1;
  localparam int unsigned WARN_RATE15  = 2;
  localparam int unsigned WARN_BPS     = 3;
  localparam int unsigned WARN_BSCODE0 = 4;

endpackage

@@ hdl/flac_stream_header_parser_unit.sv @@
// ----------------------------------------------------------------------------
// flac_stream_header_parser_unit
// Byte-serial parser for the FLAC marker, STREAMINFO, metadata skipping and
// frame headers; one result per STREAMINFO, per frame header or per error.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | stream_byte_i
//  out     | output    | out_valid_o/out_ready_i | kind_o, rate_hz_o, ...crc_o
//
//  - One byte per cycle sustained while results drain; a byte enters the
//    input register when taken, and its result is then loaded into the
//    result register.
//  - All per-byte work is a single small state update between the input
//    register and the result register.
//  - rst_ni clears the parser state and both valid flags; payload registers
//    are not reset.
//  - A stalled result holds the result register; the input register takes
//    at most one more byte, then in_ready_o stays low until the result drains.
//  - After any error the parser is halted: bytes are taken and dropped until
//    reset.
// ----------------------------------------------------------------------------
module flac_stream_header_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [19:0] rate_hz_o,
  output logic [3:0]  channel_count_o,
  output logic [5:0]  sample_size_o,
  output logic [16:0] block_size_o,
  output logic [35:0] position_number_o,
  output logic        variable_block_o,
  output logic [4:0]  warnings_o,
  output logic [7:0]  header_crc_o
);

  // Parser phases
  localparam logic [3:0] PH_MARKER    = 4'd0;
  localparam logic [3:0] PH_SI_HDR    = 4'd1;
  localparam logic [3:0] PH_SI_BODY   = 4'd2;
  localparam logic [3:0] PH_META_HDR  = 4'd3;
  localparam logic [3:0] PH_META_SKIP = 4'd4;
  localparam logic [3:0] PH_FR_HDR    = 4'd5;
  localparam logic [3:0] PH_FR_LEAD   = 4'd6;
  localparam logic [3:0] PH_FR_CONT   = 4'd7;
  localparam logic [3:0] PH_FR_EXTRA  = 4'd8;
  localparam logic [3:0] PH_FR_CRC    = 4'd9;

  // Count of leading one bits of a UTF-8 lead byte (0..8)
  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int k = 7; k >= 0; k--) begin
      if (run && b[k]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic logic [2:0] bs_extra(input logic [3:0] code);
    if (code == flacp_pkg::BS_CODE_8BIT)  return 3'd1;
    if (code == flacp_pkg::BS_CODE_16BIT) return 3'd2;
    return 3'd0;
  endfunction

  function automatic logic [2:0] rate_extra(input logic [3:0] code);
    if (code == flacp_pkg::RATE_CODE_8BIT) return 3'd1;
    if (code == flacp_pkg::RATE_CODE_16 || code == flacp_pkg::RATE_CODE_16X) return 3'd2;
    return 3'd0;
  endfunction

  // ---------------------------------------------------------------- input reg
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       consume;

  assign consume    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= stream_byte_i;
    end
  end

  // ---------------------------------------------------------------- state
  logic [3:0]  phase_q,       phase_d;
  logic [23:0] byte_count_q,  byte_count_d;
  logic [63:0] acc_q,         acc_d;
  logic        last_q,        last_d;
  logic [19:0] srate_q,       srate_d;
  logic [31:0] ff_q,          ff_d;
  logic [2:0]  utf8_rem_q,    utf8_rem_d;
  logic        halted_q,      halted_d;
  logic [31:0] extra_acc_q,   extra_acc_d;
  logic [2:0]  extra_left_q,  extra_left_d;

  // result
  logic        emit;
  logic [2:0]  r_kind;
  logic [19:0] r_rate;
  logic [3:0]  r_ch;
  logic [5:0]  r_size;
  logic [16:0] r_bs;
  logic [35:0] r_pos;
  logic        r_var;
  logic [4:0]  r_warn;
  logic [7:0]  r_crc;

  // scratch
  logic [31:0] hdr_w;
  logic [23:0] cnt_inc;
  logic [3:0]  n_lead;
  logic [3:0]  bc, rc, chc;
  logic [2:0]  after_left;
  logic [2:0]  rbytes;
  logic [15:0] rext;
  logic [15:0] bext;
  logic [5:0]  si_bps;
  logic [19:0] si_rate;

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    acc_d        = acc_q;
    last_d       = last_q;
    srate_d      = srate_q;
    ff_d         = ff_q;
    utf8_rem_d   = utf8_rem_q;
    halted_d     = halted_q;
    extra_acc_d  = extra_acc_q;
    extra_left_d = extra_left_q;

    emit   = 1'b0;
    r_kind = flacp_pkg::KIND_STREAMINFO;
    r_rate = '0;
    r_ch   = '0;
    r_size = '0;
    r_bs   = '0;
    r_pos  = '0;
    r_var  = 1'b0;
    r_warn = '0;
    r_crc  = '0;

    hdr_w   = {acc_q[23:0], byte_q};
    cnt_inc = byte_count_q + 24'd1;
    n_lead  = lead_ones(byte_q);

    // frame code fields, used after the number and at the CRC byte
    bc  = ff_q[15:12];
    rc  = ff_q[11:8];
    chc = ff_q[7:4];
    after_left = bs_extra(bc) + rate_extra(rc);
    rbytes = rate_extra(rc);
    rext = (rbytes == 3'd2) ? extra_acc_q[15:0] :
           (rbytes == 3'd1) ? {8'd0, extra_acc_q[7:0]} : 16'd0;
    bext = (rbytes == 3'd2) ? extra_acc_q[31:16] :
           (rbytes == 3'd1) ? extra_acc_q[23:8] : extra_acc_q[15:0];

    si_rate = acc_q[55:36];
    si_bps  = {1'b0, acc_q[32:28]} + 6'd1;

    if (consume && !halted_q) begin
      unique case (phase_q)
        PH_MARKER, PH_SI_HDR, PH_META_HDR, PH_FR_HDR: begin
          if (cnt_inc < 24'd4) begin
            byte_count_d = cnt_inc;
            acc_d        = {32'd0, hdr_w};
          end else begin
            byte_count_d = '0;
            acc_d        = '0;
            unique case (phase_q)
              PH_MARKER: begin
                if (hdr_w != flacp_pkg::STREAM_MARKER) begin
                  emit = 1'b1; r_kind = flacp_pkg::KIND_BAD_MARKER; halted_d = 1'b1;
                end else begin
                  phase_d = PH_SI_HDR;
                end
              end
              PH_SI_HDR: begin
                if (hdr_w[30:24] != 7'd0) begin
                  emit = 1'b1; r_kind = flacp_pkg::KIND_NOT_SINFO; halted_d = 1'b1;
                end else begin
                  last_d  = hdr_w[31];
                  ff_d    = '0;
                  phase_d = PH_SI_BODY;
                end
              end
              PH_META_HDR: begin
                last_d       = hdr_w[31];
                byte_count_d = hdr_w[23:0];
                if (hdr_w[23:0] == 24'd0) begin
                  phase_d = hdr_w[31] ? PH_FR_HDR : PH_META_HDR;
                end else begin
                  phase_d = PH_META_SKIP;
                end
              end
              default: begin
                if (hdr_w[31:18] != flacp_pkg::FRAME_SYNC) begin
                  emit = 1'b1; r_kind = flacp_pkg::KIND_BAD_SYNC; halted_d = 1'b1;
                end else begin
                  ff_d    = hdr_w;
                  phase_d = PH_FR_LEAD;
                end
              end
            endcase
          end
        end

        PH_SI_BODY: begin
          byte_count_d = cnt_inc;
          if (byte_count_q < flacp_pkg::SI_FF_BYTES) begin
            ff_d = {ff_q[23:0], byte_q};
          end else if (byte_count_q >= flacp_pkg::SI_FIRST_ACC &&
                       byte_count_q <= flacp_pkg::SI_LAST_ACC) begin
            acc_d = {acc_q[55:0], byte_q};
          end
          if (byte_count_q == flacp_pkg::SI_LAST_ACC) begin
            // acc_d now holds the 64-bit rate/channels/bps/total word
            emit = 1'b1;
            if (si_rate == 20'd0) begin
              r_kind   = flacp_pkg::KIND_ZERO_RATE;
              halted_d = 1'b1;
            end else begin
              srate_d = si_rate;
              r_kind  = flacp_pkg::KIND_STREAMINFO;
              r_rate  = si_rate;
              r_ch    = {1'b0, acc_q[35:33]} + 4'd1;
              r_size  = si_bps;
              r_bs    = {1'b0, ff_q[15:0]};
              r_pos   = {acc_q[27:0], byte_q};
              r_var   = ff_q[31:16] != ff_q[15:0];
              r_warn[flacp_pkg::WARN_BPS] = si_bps < 6'd4;
            end
          end else if (byte_count_q >= flacp_pkg::SI_LAST_BYTE) begin
            phase_d      = last_q ? PH_FR_HDR : PH_META_HDR;
            byte_count_d = '0;
            acc_d        = '0;
          end
        end

        PH_META_SKIP: begin
          if (byte_count_q > 24'd1) begin
            byte_count_d = byte_count_q - 24'd1;
          end else begin
            phase_d      = last_q ? PH_FR_HDR : PH_META_HDR;
            byte_count_d = '0;
            acc_d        = '0;
          end
        end

        PH_FR_LEAD: begin
          utf8_rem_d = 3'd0;
          if (n_lead == 4'd0) begin
            acc_d = {56'd0, byte_q};
          end else if (n_lead == 4'd1) begin
            acc_d = {58'd0, byte_q[5:0]};
          end else if (n_lead <= 4'd7) begin
            acc_d      = {56'd0, byte_q & (8'h7F >> n_lead)};
            utf8_rem_d = n_lead[2:0] - 3'd1;
          end else begin
            acc_d      = '0;
            utf8_rem_d = 3'd6;
          end
          if (utf8_rem_d == 3'd0) begin
            extra_left_d = after_left;
            extra_acc_d  = '0;
            phase_d      = (after_left != 3'd0) ? PH_FR_EXTRA : PH_FR_CRC;
          end else begin
            phase_d = PH_FR_CONT;
          end
        end

        PH_FR_CONT: begin
          acc_d = {28'd0, acc_q[29:0], byte_q[5:0]};
          if (utf8_rem_q > 3'd1) begin
            utf8_rem_d = utf8_rem_q - 3'd1;
          end else begin
            utf8_rem_d   = 3'd0;
            extra_left_d = after_left;
            extra_acc_d  = '0;
            phase_d      = (after_left != 3'd0) ? PH_FR_EXTRA : PH_FR_CRC;
          end
        end

        PH_FR_EXTRA: begin
          extra_acc_d = {extra_acc_q[23:0], byte_q};
          if (extra_left_q > 3'd1) begin
            extra_left_d = extra_left_q - 3'd1;
          end else begin
            extra_left_d = 3'd0;
            phase_d      = PH_FR_CRC;
          end
        end

        PH_FR_CRC: begin
          emit   = 1'b1;
          r_kind = flacp_pkg::KIND_FRAME;
          // blocksize
          if (bc == 4'd0) begin
            r_bs = '0;
            r_warn[flacp_pkg::WARN_BSCODE0] = 1'b1;
          end else if (bc == 4'd1) begin
            r_bs = flacp_pkg::BS_CODE1;
          end else if (bc <= 4'd5) begin
            r_bs = flacp_pkg::BS_BASE_576 << (bc[1:0] - 2'd2);
          end else if (bc == flacp_pkg::BS_CODE_8BIT) begin
            r_bs = {9'd0, bext[7:0]} + 17'd1;
          end else if (bc == flacp_pkg::BS_CODE_16BIT) begin
            r_bs = {1'b0, bext} + 17'd1;
          end else begin
            r_bs = flacp_pkg::BS_BASE_256 << bc[2:0];
          end
          // sample rate
          if (rc <= 4'd11) begin
            r_rate = srate_q;
          end else if (rc == flacp_pkg::RATE_CODE_16X) begin
            r_rate = {1'b0, rext, 3'd0} + {3'd0, rext, 1'b0};
          end else if (rc == flacp_pkg::RATE_CODE_NONE) begin
            r_rate = '0;
            r_warn[flacp_pkg::WARN_RATE15] = 1'b1;
          end else begin
            r_rate = {4'd0, rext};
          end
          r_warn[flacp_pkg::WARN_RES1] = ff_q[17];
          r_warn[flacp_pkg::WARN_RES2] = ff_q[0];
          r_ch   = (chc <= 4'd7) ? chc + 4'd1 : ((chc <= 4'd10) ? 4'd2 : 4'd0);
          r_size = {3'd0, ff_q[3:1]};
          r_pos  = acc_q[35:0];
          r_var  = ff_q[16];
          r_crc  = byte_q;
          phase_d      = PH_FR_HDR;
          byte_count_d = '0;
          acc_d        = '0;
        end

        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_MARKER;
      byte_count_q <= '0;
      acc_q        <= '0;
      last_q       <= 1'b0;
      srate_q      <= '0;
      ff_q         <= '0;
      utf8_rem_q   <= '0;
      halted_q     <= 1'b0;
      extra_acc_q  <= '0;
      extra_left_q <= '0;
    end else begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      acc_q        <= acc_d;
      last_q       <= last_d;
      srate_q      <= srate_d;
      ff_q         <= ff_d;
      utf8_rem_q   <= utf8_rem_d;
      halted_q     <= halted_d;
      extra_acc_q  <= extra_acc_d;
      extra_left_q <= extra_left_d;
    end
  end

  // ---------------------------------------------------------------- result reg
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume) begin
      out_valid_q <= emit && !halted_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && emit) begin
      kind_o            <= r_kind;
      rate_hz_o         <= r_rate;
      channel_count_o   <= r_ch;
      sample_size_o     <= r_size;
      block_size_o      <= r_bs;
      position_number_o <= r_pos;
      variable_block_o  <= r_var;
      warnings_o        <= r_warn;
      header_crc_o      <= r_crc;
    end
  end

  // ---------------------------------------------------------------- checks
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("parser left the halted state without reset");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != flacp_pkg::KIND_STREAMINFO &&
    kind_o != flacp_pkg::KIND_FRAME |-> halted_q)
    else $error("error result while parser still running");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != flacp_pkg::KIND_STREAMINFO &&
    kind_o != flacp_pkg::KIND_FRAME |->
    rate_hz_o == '0 && block_size_o == '0 && position_number_o == '0 &&
    warnings_o == '0 && header_crc_o == '0)
    else $error("error result carries nonzero fields");

  a_frame_no_bps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == flacp_pkg::KIND_FRAME |-> !warnings_o[flacp_pkg::WARN_BPS])
    else $error("frame result flags streaminfo bps warning");

  a_extra_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FR_EXTRA |-> extra_left_q != 3'd0)
    else $error("extra byte phase with nothing left to read");

endmodule

@@ tb/flac_stream_header_parser_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flac_stream_header_parser_unit_test
// Sends one FLAC byte stream through the parser and checks its results.
// The stream is: the marker, a STREAMINFO with random fields, some metadata
// blocks to skip, directed frames for each blocksize and rate family, channel
// edges and number length, then random frame headers. It closes with a bad
// sync word and a tail of bytes the halted parser must drop. A parser model
// in this file predicts every result. Both handshakes get random gaps.
// ----------------------------------------------------------------------------
module flac_stream_header_parser_unit_test;

  localparam int unsigned HALF_PERIOD  = 1;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned RANDOM_BYTES = 900;
  localparam int unsigned TAIL_BYTES   = 24;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned IDLE_LIGHT   = 12;
  localparam int unsigned IDLE_HEAVY   = 53;

  // Codes and limits that the package has no name for
  localparam logic [3:0]  BS_CODE_NONE      = 4'd0;
  localparam logic [3:0]  BS_CODE_192       = 4'd1;
  localparam logic [3:0]  BS_CODE_576_MIN   = 4'd2;
  localparam logic [3:0]  BS_CODE_576_MAX   = 4'd5;
  localparam logic [3:0]  BS_CODE_256_MIN   = 4'd8;
  localparam logic [3:0]  BS_CODE_256_MAX   = 4'd15;
  localparam logic [3:0]  RATE_CODE_SINFO   = 4'd11;  // codes up to here use STREAMINFO
  localparam logic [3:0]  CH_CODE_INDEP_MAX = 4'd7;
  localparam logic [3:0]  CH_CODE_STEREO    = 4'd10;
  localparam logic [6:0]  META_STREAMINFO   = 7'd0;
  localparam logic [23:0] HDR_WORD_BYTES    = 24'd4;
  localparam logic [5:0]  BPS_LOW_LIMIT     = 6'd4;
  localparam int unsigned RATE_SCALE        = 10;
  localparam int unsigned MAX_LEAD_ONES     = 8;

  typedef enum logic [3:0] {
    ST_MARKER, ST_SINFO_HDR, ST_SINFO_BODY, ST_BLOCK_HDR, ST_BLOCK_SKIP,
    ST_FRAME_HDR, ST_NUM_LEAD, ST_NUM_CONT, ST_FRAME_EXTRA, ST_FRAME_CRC
  } parse_state_e;

  typedef enum logic [1:0] {
    PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL_RATE
  } pace_e;

  typedef struct packed {
    flacp_pkg::kind_e kind;
    logic [19:0] rate;
    logic [3:0]  ch;
    logic [5:0]  bits;
    logic [16:0] bsize;
    logic [35:0] pos;
    logic        vb;
    logic [4:0]  warn;
    logic [7:0]  crc;
  } hdr_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [2:0]  kind_o;
  logic [19:0] rate_hz_o;
  logic [3:0]  channel_count_o;
  logic [5:0]  sample_size_o;
  logic [16:0] block_size_o;
  logic [35:0] position_number_o;
  logic        variable_block_o;
  logic [4:0]  warnings_o;
  logic [7:0]  header_crc_o;

  logic [7:0]  stream_bytes_q[$];
  hdr_result_t expected_hdrs_q[$];

  int unsigned total_bytes   = 0;
  int unsigned bytes_taken   = 0;
  int unsigned mismatches    = 0;
  int unsigned n_sinfo       = 0;
  int unsigned n_frames      = 0;
  int unsigned n_err_results = 0;
  int unsigned cycle_count   = 0;
  pace_e       pace          = PACE_SLOW_SINK;

  // Parser model state
  parse_state_e prs_state      = ST_MARKER;
  logic [23:0]  prs_count      = '0;
  logic [63:0]  prs_shift      = '0;
  logic         prs_last_meta  = 1'b0;
  logic [19:0]  prs_stream_rate = '0;
  logic [31:0]  prs_hdr_word   = '0;
  int unsigned  prs_utf8_left  = 0;
  logic         prs_halted     = 1'b0;
  logic [31:0]  prs_extra      = '0;
  int unsigned  prs_extra_left = 0;

  flac_stream_header_parser_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .stream_byte_i     (stream_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .rate_hz_o         (rate_hz_o),
    .channel_count_o   (channel_count_o),
    .sample_size_o     (sample_size_o),
    .block_size_o      (block_size_o),
    .position_number_o (position_number_o),
    .variable_block_o  (variable_block_o),
    .warnings_o        (warnings_o),
    .header_crc_o      (header_crc_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic int unsigned blocksize_tail_bytes(input logic [3:0] code);
    if (code == flacp_pkg::BS_CODE_8BIT) return 1;
    if (code == flacp_pkg::BS_CODE_16BIT) return 2;
    return 0;
  endfunction

  function automatic int unsigned rate_tail_bytes(input logic [3:0] code);
    if (code == flacp_pkg::RATE_CODE_8BIT) return 1;
    if (code == flacp_pkg::RATE_CODE_16 || code == flacp_pkg::RATE_CODE_16X) return 2;
    return 0;
  endfunction

  task automatic raise_error(input flacp_pkg::kind_e k);
    hdr_result_t r;
    r = '0;
    r.kind = k;
    expected_hdrs_q.push_back(r);
    prs_halted = 1'b1;
  endtask

  task automatic end_of_metadata;
    prs_state = prs_last_meta ? ST_FRAME_HDR : ST_BLOCK_HDR;
    prs_count = '0;
    prs_shift = '0;
  endtask

  // Coded number done: fetch optional blocksize/rate bytes, then the CRC byte
  task automatic finish_number;
    prs_extra_left = blocksize_tail_bytes(prs_hdr_word[15:12]) +
                     rate_tail_bytes(prs_hdr_word[11:8]);
    prs_extra = '0;
    prs_state = (prs_extra_left != 0) ? ST_FRAME_EXTRA : ST_FRAME_CRC;
  endtask

  task automatic parse_stream_byte(input logic [7:0] b);
    hdr_result_t r;
    logic [31:0] w;
    logic [31:0] bs_ext;
    logic [31:0] rate_ext;
    logic [31:0] bsz;
    logic [31:0] rate;
    logic [3:0]  bc;
    logic [3:0]  rc;
    logic [3:0]  ch;
    logic [5:0]  bps;
    int unsigned idx;
    int unsigned ones;
    int unsigned rbytes;
    r = '0;
    if (!prs_halted) begin
      case (prs_state)
        // All four header words are collected the same way
        ST_MARKER, ST_SINFO_HDR, ST_BLOCK_HDR, ST_FRAME_HDR: begin
          prs_shift = {32'd0, prs_shift[23:0], b};
          prs_count = prs_count + 24'd1;
          if (prs_count >= HDR_WORD_BYTES) begin
            w = prs_shift[31:0];
            prs_count = '0;
            prs_shift = '0;
            case (prs_state)
              ST_MARKER: begin
                if (w != flacp_pkg::STREAM_MARKER) raise_error(flacp_pkg::KIND_BAD_MARKER);
                else prs_state = ST_SINFO_HDR;
              end
              ST_SINFO_HDR: begin
                if (w[30:24] != META_STREAMINFO) begin
                  raise_error(flacp_pkg::KIND_NOT_SINFO);
                end else begin
                  prs_last_meta = w[31];
                  prs_hdr_word = '0;
                  prs_state = ST_SINFO_BODY;
                end
              end
              ST_BLOCK_HDR: begin
                prs_last_meta = w[31];
                prs_count = w[23:0];
                if (prs_count == '0) end_of_metadata();
                else prs_state = ST_BLOCK_SKIP;
              end
              default: begin
                if (w[31:18] != flacp_pkg::FRAME_SYNC) begin
                  raise_error(flacp_pkg::KIND_BAD_SYNC);
                end else begin
                  prs_hdr_word = w;
                  prs_state = ST_NUM_LEAD;
                end
              end
            endcase
          end
        end
        ST_SINFO_BODY: begin
          // Body is always 34 bytes: block sizes up front, packed info at 10..17
          idx = prs_count;
          prs_count = prs_count + 24'd1;
          if (idx < flacp_pkg::SI_FF_BYTES) begin
            prs_hdr_word = {prs_hdr_word[23:0], b};
          end else if (idx >= flacp_pkg::SI_FIRST_ACC && idx <= flacp_pkg::SI_LAST_ACC) begin
            prs_shift = {prs_shift[55:0], b};
          end
          if (idx == flacp_pkg::SI_LAST_ACC) begin
            if (prs_shift[63:44] == '0) begin
              raise_error(flacp_pkg::KIND_ZERO_RATE);
            end else begin
              bps = {1'b0, prs_shift[40:36]} + 6'd1;
              prs_stream_rate = prs_shift[63:44];
              r.kind = flacp_pkg::KIND_STREAMINFO;
              r.rate = prs_shift[63:44];
              r.ch = {1'b0, prs_shift[43:41]} + 4'd1;
              r.bits = bps;
              r.bsize = {1'b0, prs_hdr_word[15:0]};
              r.pos = prs_shift[35:0];
              r.vb = prs_hdr_word[31:16] != prs_hdr_word[15:0];
              r.warn[flacp_pkg::WARN_BPS] = bps < BPS_LOW_LIMIT;
              expected_hdrs_q.push_back(r);
            end
          end else if (idx >= flacp_pkg::SI_LAST_BYTE) begin
            end_of_metadata();
          end
        end
        ST_BLOCK_SKIP: begin
          if (prs_count != '0) prs_count = prs_count - 24'd1;
          if (prs_count == '0) end_of_metadata();
        end
        ST_NUM_LEAD: begin
          ones = 0;
          while (ones < MAX_LEAD_ONES && b[7 - ones]) ones++;
          if (ones == 0) begin
            prs_shift = {56'd0, b};
            prs_utf8_left = 0;
          end else if (ones == 1) begin
            // stray continuation byte as lead: one-byte number of its low bits
            prs_shift = {58'd0, b[5:0]};
            prs_utf8_left = 0;
          end else if (ones < MAX_LEAD_ONES) begin
            prs_shift = {56'd0, b & (8'h7F >> ones)};
            prs_utf8_left = ones - 1;
          end else begin
            // 0xFF lead acts like 0xFE
            prs_shift = '0;
            prs_utf8_left = 6;
          end
          if (prs_utf8_left != 0) prs_state = ST_NUM_CONT;
          else finish_number();
        end
        ST_NUM_CONT: begin
          // top bits of continuation bytes are not checked; number kept to 36 bits
          prs_shift = {28'd0, prs_shift[29:0], b[5:0]};
          if (prs_utf8_left != 0) prs_utf8_left--;
          if (prs_utf8_left == 0) finish_number();
        end
        ST_FRAME_EXTRA: begin
          prs_extra = {prs_extra[23:0], b};
          if (prs_extra_left != 0) prs_extra_left--;
          if (prs_extra_left == 0) prs_state = ST_FRAME_CRC;
        end
        default: begin
          // CRC byte closes the frame header
          bc = prs_hdr_word[15:12];
          rc = prs_hdr_word[11:8];
          ch = prs_hdr_word[7:4];
          rbytes = rate_tail_bytes(rc);
          rate_ext = (rbytes == 2) ? {16'd0, prs_extra[15:0]} :
                     (rbytes == 1) ? {24'd0, prs_extra[7:0]} : 32'd0;
          bs_ext = prs_extra >> (8 * rbytes);
          r.kind = flacp_pkg::KIND_FRAME;
          if (bc == BS_CODE_NONE) begin
            bsz = '0;
            r.warn[flacp_pkg::WARN_BSCODE0] = 1'b1;
          end else if (bc == BS_CODE_192) begin
            bsz = 32'(flacp_pkg::BS_CODE1);
          end else if (bc <= BS_CODE_576_MAX) begin
            bsz = 32'(flacp_pkg::BS_BASE_576) << (bc - BS_CODE_576_MIN);
          end else if (bc == flacp_pkg::BS_CODE_8BIT) begin
            bsz = {24'd0, bs_ext[7:0]} + 32'd1;
          end else if (bc == flacp_pkg::BS_CODE_16BIT) begin
            bsz = {16'd0, bs_ext[15:0]} + 32'd1;
          end else begin
            bsz = 32'(flacp_pkg::BS_BASE_256) << (bc - BS_CODE_256_MIN);
          end
          if (rc <= RATE_CODE_SINFO) begin
            rate = {12'd0, prs_stream_rate};
          end else if (rc == flacp_pkg::RATE_CODE_16X) begin
            rate = rate_ext * RATE_SCALE;
          end else if (rc == flacp_pkg::RATE_CODE_NONE) begin
            rate = '0;
            r.warn[flacp_pkg::WARN_RATE15] = 1'b1;
          end else begin
            rate = rate_ext;
          end
          r.warn[flacp_pkg::WARN_RES1] = prs_hdr_word[17];
          r.warn[flacp_pkg::WARN_RES2] = prs_hdr_word[0];
          r.rate = rate[19:0];
          r.ch = (ch <= CH_CODE_INDEP_MAX) ? ch + 4'd1 :
                 (ch <= CH_CODE_STEREO) ? 4'd2 : 4'd0;
          r.bits = {3'd0, prs_hdr_word[3:1]};
          r.bsize = bsz[16:0];
          r.pos = prs_shift[35:0];
          r.vb = prs_hdr_word[16];
          r.crc = b;
          expected_hdrs_q.push_back(r);
          prs_state = ST_FRAME_HDR;
          prs_count = '0;
          prs_shift = '0;
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Stream builders
  // --------------------------------------------------------------------------
  task automatic push_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) stream_bytes_q.push_back(w[8*k +: 8]);
  endtask

  task automatic push_random_bytes(input int unsigned n);
    repeat (n) stream_bytes_q.push_back(8'($urandom));
  endtask

  task automatic push_streaminfo(input logic last_flag);
    logic [15:0] min_bs;
    logic [15:0] max_bs;
    logic [19:0] rate;
    logic [4:0]  bps_code;
    logic [63:0] info;
    max_bs = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
    min_bs = $urandom_range(0, 1) ? max_bs : 16'($urandom);
    rate = $urandom_range(0, 1) ? 20'hFFFFF : 20'($urandom_range(1, 20'hFFFFF));
    case ($urandom_range(0, 3))
      0: bps_code = 5'd0;
      1: bps_code = 5'd31;
      default: bps_code = 5'($urandom);
    endcase
    info = {rate, 3'($urandom), bps_code, 4'($urandom), 32'($urandom)};
    // length field is ignored by the parser, so any value goes
    push_word({last_flag, META_STREAMINFO, 24'($urandom)});
    push_word({min_bs, max_bs});
    push_random_bytes(6);
    push_word(info[63:32]);
    push_word(info[31:0]);
    push_random_bytes(16);
  endtask

  task automatic push_metadata(input logic last_flag, input logic [23:0] len);
    push_word({last_flag, 7'($urandom), len});
    push_random_bytes(len);
  endtask

  // ones: leading one bits of the number's lead byte (0..8)
  task automatic push_frame(input logic [3:0] bc, input logic [3:0] rc,
                            input logic [3:0] ch, input int unsigned ones,
                            input logic [31:0] extra, input logic [1:0] res_bits,
                            input logic max_num);
    logic [7:0]  lead;
    logic [7:0]  low_bits;
    int unsigned n_cont;
    int unsigned n_extra;
    push_word({flacp_pkg::FRAME_SYNC, res_bits[1], 1'($urandom), bc, rc, ch,
               3'($urandom), res_bits[0]});
    low_bits = max_num ? 8'hFF : 8'($urandom);
    if (ones >= MAX_LEAD_ONES) lead = 8'hFF;
    else lead = (8'hFF << (8 - ones)) | (low_bits & (8'h7F >> ones));
    stream_bytes_q.push_back(lead);
    n_cont = (ones <= 1) ? 0 : (ones >= MAX_LEAD_ONES) ? 6 : ones - 1;
    repeat (n_cont) begin
      if (max_num) stream_bytes_q.push_back(8'hBF);
      else if ($urandom_range(0, 15) == 0) stream_bytes_q.push_back(8'($urandom));
      else stream_bytes_q.push_back({2'b10, 6'($urandom)});
    end
    n_extra = blocksize_tail_bytes(bc) + rate_tail_bytes(rc);
    for (int k = int'(n_extra) - 1; k >= 0; k--) stream_bytes_q.push_back(extra[8*k +: 8]);
    stream_bytes_q.push_back(8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Request driver: one byte in flight, held until taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_requests
    logic        busy;
    int unsigned idle_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      busy = in_valid_i && !in_ready_o;
      if (in_valid_i && in_ready_o) begin
        parse_stream_byte(stream_byte_i);
        bytes_taken++;
      end
      pace <= (bytes_taken < total_bytes / 3) ? PACE_SLOW_SINK :
              (bytes_taken < 2 * total_bytes / 3) ? PACE_SLOW_SOURCE : PACE_FULL_RATE;
      idle_pct = (pace == PACE_SLOW_SINK) ? IDLE_LIGHT :
                 (pace == PACE_SLOW_SOURCE) ? IDLE_HEAVY : 0;
      if (!busy) begin
        if (stream_bytes_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          stream_byte_i <= stream_bytes_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result sink stalls
  always @(posedge clk_i) begin : drive_sink
    int unsigned stall_pct;
    stall_pct = (pace == PACE_SLOW_SINK) ? IDLE_HEAVY :
                (pace == PACE_SLOW_SOURCE) ? IDLE_LIGHT : 0;
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= $urandom_range(0, 99) >= stall_pct;
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [35:0] exp_v,
                             input logic [35:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    hdr_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_hdrs_q.size() == 0) begin
        $error("unexpected result, kind %0d", kind_o);
        mismatches++;
      end else begin
        exp_r = expected_hdrs_q.pop_front();
        check_field("kind", exp_r.kind, kind_o);
        check_field("rate_hz", exp_r.rate, rate_hz_o);
        check_field("channel_count", exp_r.ch, channel_count_o);
        check_field("sample_size", exp_r.bits, sample_size_o);
        check_field("block_size", exp_r.bsize, block_size_o);
        check_field("position_number", exp_r.pos, position_number_o);
        check_field("variable_block", exp_r.vb, variable_block_o);
        check_field("warnings", exp_r.warn, warnings_o);
        check_field("header_crc", exp_r.crc, header_crc_o);
        if (exp_r.kind == flacp_pkg::KIND_STREAMINFO) n_sinfo++;
        else if (exp_r.kind == flacp_pkg::KIND_FRAME) n_frames++;
        else n_err_results++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stream build, reset and end of run
  // --------------------------------------------------------------------------
  initial begin : run
    logic        sinfo_last;
    int unsigned n_blocks;
    int unsigned random_start;
    sinfo_last = ($urandom_range(0, 4) == 0);

    push_word(flacp_pkg::STREAM_MARKER);
    push_streaminfo(sinfo_last);
    if (!sinfo_last) begin
      // empty block, one-byte block, a few random ones, then the last one
      push_metadata(1'b0, 24'd0);
      push_metadata(1'b0, 24'd1);
      n_blocks = $urandom_range(0, 3);
      repeat (n_blocks) push_metadata(1'b0, 24'($urandom_range(0, 40)));
      push_metadata(1'b1, 24'($urandom_range(0, 12)));
    end

    // Directed frames: every blocksize/rate family, channel edges, number forms
    push_frame(BS_CODE_NONE, 4'd0, 4'd0, 0, 32'h0, 2'b11, 1'b0);
    push_frame(BS_CODE_192, flacp_pkg::RATE_CODE_8BIT, CH_CODE_INDEP_MAX, 1, 32'hFF,
               2'b10, 1'b1);
    push_frame(BS_CODE_576_MIN, flacp_pkg::RATE_CODE_16, 4'd8, 2, 32'hFFFF, 2'b01, 1'b0);
    push_frame(BS_CODE_576_MAX, flacp_pkg::RATE_CODE_16X, CH_CODE_STEREO, 3, 32'hFFFF,
               2'b00, 1'b1);
    push_frame(flacp_pkg::BS_CODE_8BIT, flacp_pkg::RATE_CODE_NONE, 4'd11, 7, 32'hFF,
               2'b00, 1'b1);
    push_frame(flacp_pkg::BS_CODE_16BIT, RATE_CODE_SINFO, 4'd15, 8, 32'hFFFF, 2'b00, 1'b1);
    push_frame(BS_CODE_256_MIN, flacp_pkg::RATE_CODE_16X, 4'd1, 4, 32'h0, 2'b00, 1'b0);
    push_frame(BS_CODE_256_MAX, flacp_pkg::RATE_CODE_8BIT, 4'd9, 5, 32'h0, 2'b00, 1'b0);
    push_frame(flacp_pkg::BS_CODE_8BIT, flacp_pkg::RATE_CODE_16, 4'd3, 6, 32'h0,
               2'b00, 1'b0);
    push_frame(flacp_pkg::BS_CODE_16BIT, flacp_pkg::RATE_CODE_16X, 4'd2, 7, 32'hFFFF_FFFF,
               2'b00, 1'b0);
    push_frame(flacp_pkg::BS_CODE_16BIT, flacp_pkg::RATE_CODE_8BIT, 4'd5, 0, 32'h0,
               2'b00, 1'b0);

    // Random well-formed frame headers with random codes and number forms
    random_start = stream_bytes_q.size();
    while (stream_bytes_q.size() < random_start + RANDOM_BYTES)
      push_frame(4'($urandom), 4'($urandom), 4'($urandom), $urandom_range(0, 8),
                 $urandom, ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'b00,
                 $urandom_range(0, 15) == 0);

    // One flipped sync bit halts the parser; the tail must produce nothing
    push_word({flacp_pkg::FRAME_SYNC ^ (14'd1 << $urandom_range(0, 13)), 18'($urandom)});
    push_random_bytes(TAIL_BYTES);
    total_bytes = stream_bytes_q.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stream_bytes_q.size() != 0 || in_valid_i || expected_hdrs_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Took %0d stream bytes; matched %0d streaminfo, %0d frame and %0d error results",
             bytes_taken, n_sinfo, n_frames, n_err_results);
    $display("Sender and sink gaps ran in both orders, then at full rate");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ flac_stream_header_parser_unit.f @@
hdl/flacp_pkg.sv
hdl/flac_stream_header_parser_unit.sv
tb/flac_stream_header_parser_unit_test.sv
